/* rtl/sbb_pkg.sv */
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared constants and small helpers for the separable box blur.
// ----------------------------------------------------------------------------
package sbb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 7;
    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int STORE_DEPTH = WIN_DEPTH * MAX_WIDTH;

    localparam int XW  = $clog2(MAX_WIDTH);       // column index
    localparam int YW  = $clog2(MAX_HEIGHT);      // row index
    localparam int MW  = $clog2(WIN_DEPTH);       // index modulo window depth
    localparam int AW  = MW + XW;                 // line store address
    localparam int SW  = 12;                      // channel sum, 15 * 255 max
    localparam int NW  = 4;                       // window count, 1..15

    localparam logic [10:0] RESET_WIDTH  = 11'd640;
    localparam logic [12:0] RESET_HEIGHT = 13'd480;
    localparam logic [2:0]  RESET_RADIUS = 3'd1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_NONE   = 2'd3;     // unused index

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    function automatic logic [MW-1:0] mod_sub(input logic [MW-1:0] a, input logic [2:0] d);
        logic [MW:0] t;
        t = {1'b0, a} - {{(MW-2){1'b0}}, d};
        if (t[MW]) begin
            t = t + (MW+1)'(WIN_DEPTH);
        end
        return t[MW-1:0];
    endfunction

    function automatic logic [MW-1:0] mod_inc(input logic [MW-1:0] a);
        logic [MW-1:0] t;
        t = (a == MW'(WIN_DEPTH - 1)) ? '0 : a + 1'b1;
        return t;
    endfunction

endpackage

/* rtl/separable_box_blur_rgb.sv */
// ----------------------------------------------------------------------------
// separable_box_blur_rgb
// Streaming RGB888 box blur, horizontal pass then vertical pass, edge clipped.
// ----------------------------------------------------------------------------
// One item is handled at a time. A pixel item passes through idle, advance and
// check states plus, for each horizontal result it completes (0, 1, or up to
// radius+1 at a row end), one setup step, a walk over the n columns in that
// result's row window, 12 shared divider steps and one line store write. A
// drain item passes through idle and check only; an ignored excess pixel stays
// in idle. An emitted output adds a registered line store read and an
// accumulate per row in its window, 12 divider steps and one output step, plus
// any wait for the previous output item to be taken. The line store is a
// single-port-write, registered-read memory of 15 rows of 1024 pixels; it
// needs no clearing after reset.
module separable_box_blur_rgb (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic        m_frame_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_HSET, S_HSUM, S_DIV, S_HWR, S_ADV, S_CHECK, S_VRD, S_VACC, S_OUT
    } state_t;

    localparam int XW = sbb_pkg::XW;
    localparam int YW = sbb_pkg::YW;
    localparam int MW = sbb_pkg::MW;
    localparam int SW = sbb_pkg::SW;
    localparam int NW = sbb_pkg::NW;

    state_t state_reg;

    logic [10:0] cfg_width_reg;
    logic [12:0] cfg_height_reg;
    logic [2:0]  cfg_radius_reg;

    logic [XW-1:0] in_x_reg;
    logic [YW:0]   in_y_reg;
    logic [MW-1:0] in_cmod_reg;
    logic [MW-1:0] in_ymod_reg;
    logic [XW-1:0] out_x_reg;
    logic [YW-1:0] out_y_reg;
    logic [MW-1:0] out_ymod_reg;

    logic [23:0]   row_win_reg [sbb_pkg::WIN_DEPTH];

    logic [XW-1:0] hx_reg, hend_reg, cc_reg, cend_reg;
    logic [MW-1:0] hxmod_reg, cm_reg;
    logic [YW-1:0] vy_reg, vend_reg;
    logic [MW-1:0] vym_reg;
    logic [NW-1:0] n_reg;
    logic [SW-1:0] sr_reg, sg_reg, sb_reg;
    logic [NW-1:0] rr_reg, rg_reg, rb_reg;
    logic [3:0]    dcnt_reg;
    logic          vert_reg;

    logic [23:0]   line_store_mem [sbb_pkg::STORE_DEPTH];
    logic          st_we;
    logic [sbb_pkg::AW-1:0] st_waddr, st_raddr;
    logic          st_re;
    logic [23:0]   st_rdata_reg;

    // effective configuration
    logic [10:0]   w_eff;
    logic [12:0]   h_eff;
    logic [XW-1:0] wm1;
    logic [YW-1:0] hm1;
    logic [2:0]    rad;

    always_comb begin
        w_eff = cfg_width_reg;
        if (w_eff == 11'd0) begin
            w_eff = 11'd1;
        end else if (w_eff > 11'(sbb_pkg::MAX_WIDTH)) begin
            w_eff = 11'(sbb_pkg::MAX_WIDTH);
        end
        h_eff = cfg_height_reg;
        if (h_eff == 13'd0) begin
            h_eff = 13'd1;
        end else if (h_eff > 13'(sbb_pkg::MAX_HEIGHT)) begin
            h_eff = 13'(sbb_pkg::MAX_HEIGHT);
        end
        wm1 = XW'(w_eff - 11'd1);
        hm1 = YW'(h_eff - 13'd1);
        rad = cfg_radius_reg;
    end

    // horizontal window of column hx
    logic [2:0]    hd;
    logic [XW:0]   hx1_wide;
    logic [XW-1:0] hx0, hx1;
    always_comb begin
        hd       = ({{(XW-3){1'b0}}, rad} > hx_reg) ? hx_reg[2:0] : rad;
        hx0      = hx_reg - {{(XW-3){1'b0}}, hd};
        hx1_wide = {1'b0, hx_reg} + {{(XW-2){1'b0}}, rad};
        hx1      = (hx1_wide > {1'b0, wm1}) ? wm1 : hx1_wide[XW-1:0];
    end

    // output readiness and vertical window
    logic [YW:0]   yl_wide;
    logic [XW:0]   xl_wide;
    logic [YW-1:0] ylast;
    logic [XW-1:0] xlast;
    logic [2:0]    vd;
    logic          out_ready;
    always_comb begin
        yl_wide = {1'b0, out_y_reg} + {{(YW-2){1'b0}}, rad};
        xl_wide = {1'b0, out_x_reg} + {{(XW-2){1'b0}}, rad};
        ylast   = (yl_wide > {1'b0, hm1}) ? hm1 : yl_wide[YW-1:0];
        xlast   = (xl_wide > {1'b0, wm1}) ? wm1 : xl_wide[XW-1:0];
        vd      = ({{(YW-3){1'b0}}, rad} > out_y_reg) ? out_y_reg[2:0] : rad;
        out_ready = (in_y_reg > {1'b0, ylast}) ||
                    ((in_y_reg == {1'b0, ylast}) && (in_x_reg > xlast));
    end

    // one restoring divider step per channel
    logic [NW:0]   tr, tg, tb;
    logic          br, bg, bb;
    always_comb begin
        tr = {rr_reg, sr_reg[SW-1]};
        tg = {rg_reg, sg_reg[SW-1]};
        tb = {rb_reg, sb_reg[SW-1]};
        br = (tr >= {1'b0, n_reg});
        bg = (tg >= {1'b0, n_reg});
        bb = (tb >= {1'b0, n_reg});
    end

    logic [23:0] pix_win;
    assign pix_win = row_win_reg[cm_reg];

    assign s_ready  = (state_reg == S_IDLE);
    assign st_we    = (state_reg == S_HWR);
    assign st_waddr = {in_ymod_reg, hx_reg};
    assign st_re    = (state_reg == S_VRD);
    assign st_raddr = {vym_reg, out_x_reg};

    always_ff @(posedge aclk) begin
        if (st_we) begin
            line_store_mem[st_waddr] <= {sr_reg[7:0], sg_reg[7:0], sb_reg[7:0]};
        end
        if (st_re) begin
            st_rdata_reg <= line_store_mem[st_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cfg_width_reg  <= sbb_pkg::RESET_WIDTH;
            cfg_height_reg <= sbb_pkg::RESET_HEIGHT;
            cfg_radius_reg <= sbb_pkg::RESET_RADIUS;
            in_x_reg       <= '0;
            in_y_reg       <= '0;
            in_cmod_reg    <= '0;
            in_ymod_reg    <= '0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_ymod_reg   <= '0;
            m_valid        <= 1'b0;
        end else begin
            if (m_valid && m_ready && (state_reg != S_OUT)) begin
                m_valid <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    sbb_pkg::REG_WIDTH:  cfg_width_reg  <= cfg_data[10:0];
                    sbb_pkg::REG_HEIGHT: cfg_height_reg <= cfg_data;
                    sbb_pkg::REG_RADIUS: cfg_radius_reg <= cfg_data[2:0];
                    default: ;
                endcase
                if (cfg_index != sbb_pkg::REG_NONE) begin
                    in_x_reg     <= '0;
                    in_y_reg     <= '0;
                    in_cmod_reg  <= '0;
                    in_ymod_reg  <= '0;
                    out_x_reg    <= '0;
                    out_y_reg    <= '0;
                    out_ymod_reg <= '0;
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_cmd == sbb_pkg::CMD_DRAIN) begin
                            state_reg <= S_CHECK;
                        end else if (in_y_reg < h_eff) begin
                            row_win_reg[in_cmod_reg] <= {s_in_red, s_in_green, s_in_blue};
                            if ({{(XW-3){1'b0}}, rad} <= in_x_reg) begin
                                hx_reg    <= in_x_reg - {{(XW-3){1'b0}}, rad};
                                hxmod_reg <= sbb_pkg::mod_sub(in_cmod_reg, rad);
                                hend_reg  <= (in_x_reg == wm1) ? wm1
                                           : in_x_reg - {{(XW-3){1'b0}}, rad};
                                state_reg <= S_HSET;
                            end else if (in_x_reg == wm1) begin
                                hx_reg    <= '0;
                                hxmod_reg <= '0;
                                hend_reg  <= wm1;
                                state_reg <= S_HSET;
                            end else begin
                                state_reg <= S_ADV;
                            end
                        end
                    end
                end
                S_HSET: begin
                    cc_reg    <= hx0;
                    cm_reg    <= sbb_pkg::mod_sub(hxmod_reg, hd);
                    cend_reg  <= hx1;
                    n_reg     <= NW'(hx1 - hx0 + 1'b1);
                    sr_reg    <= '0;
                    sg_reg    <= '0;
                    sb_reg    <= '0;
                    state_reg <= S_HSUM;
                end
                S_HSUM: begin
                    sr_reg <= sr_reg + {4'd0, pix_win[23:16]};
                    sg_reg <= sg_reg + {4'd0, pix_win[15:8]};
                    sb_reg <= sb_reg + {4'd0, pix_win[7:0]};
                    if (cc_reg == cend_reg) begin
                        rr_reg    <= '0;
                        rg_reg    <= '0;
                        rb_reg    <= '0;
                        dcnt_reg  <= '0;
                        vert_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end else begin
                        cc_reg <= cc_reg + 1'b1;
                        cm_reg <= sbb_pkg::mod_inc(cm_reg);
                    end
                end
                S_DIV: begin
                    rr_reg   <= br ? NW'(tr - {1'b0, n_reg}) : tr[NW-1:0];
                    rg_reg   <= bg ? NW'(tg - {1'b0, n_reg}) : tg[NW-1:0];
                    rb_reg   <= bb ? NW'(tb - {1'b0, n_reg}) : tb[NW-1:0];
                    sr_reg   <= {sr_reg[SW-2:0], br};
                    sg_reg   <= {sg_reg[SW-2:0], bg};
                    sb_reg   <= {sb_reg[SW-2:0], bb};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 4'(SW - 1)) begin
                        state_reg <= vert_reg ? S_OUT : S_HWR;
                    end
                end
                S_HWR: begin
                    if (hx_reg == hend_reg) begin
                        state_reg <= S_ADV;
                    end else begin
                        hx_reg    <= hx_reg + 1'b1;
                        hxmod_reg <= sbb_pkg::mod_inc(hxmod_reg);
                        state_reg <= S_HSET;
                    end
                end
                S_ADV: begin
                    if (in_x_reg == wm1) begin
                        in_x_reg    <= '0;
                        in_cmod_reg <= '0;
                        in_y_reg    <= in_y_reg + 1'b1;
                        in_ymod_reg <= sbb_pkg::mod_inc(in_ymod_reg);
                    end else begin
                        in_x_reg    <= in_x_reg + 1'b1;
                        in_cmod_reg <= sbb_pkg::mod_inc(in_cmod_reg);
                    end
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (out_ready) begin
                        vy_reg    <= out_y_reg - {{(YW-3){1'b0}}, vd};
                        vym_reg   <= sbb_pkg::mod_sub(out_ymod_reg, vd);
                        vend_reg  <= ylast;
                        n_reg     <= NW'(ylast - out_y_reg + {{(YW-3){1'b0}}, vd} + 1'b1);
                        sr_reg    <= '0;
                        sg_reg    <= '0;
                        sb_reg    <= '0;
                        state_reg <= S_VRD;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_VRD: begin
                    state_reg <= S_VACC;
                end
                S_VACC: begin
                    sr_reg <= sr_reg + {4'd0, st_rdata_reg[23:16]};
                    sg_reg <= sg_reg + {4'd0, st_rdata_reg[15:8]};
                    sb_reg <= sb_reg + {4'd0, st_rdata_reg[7:0]};
                    if (vy_reg == vend_reg) begin
                        rr_reg    <= '0;
                        rg_reg    <= '0;
                        rb_reg    <= '0;
                        dcnt_reg  <= '0;
                        vert_reg  <= 1'b1;
                        state_reg <= S_DIV;
                    end else begin
                        vy_reg    <= vy_reg + 1'b1;
                        vym_reg   <= sbb_pkg::mod_inc(vym_reg);
                        state_reg <= S_VRD;
                    end
                end
                S_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid      <= 1'b1;
                        m_out_red    <= sr_reg[7:0];
                        m_out_green  <= sg_reg[7:0];
                        m_out_blue   <= sb_reg[7:0];
                        m_frame_last <= (out_x_reg == wm1) && (out_y_reg == hm1);
                        if ((out_x_reg == wm1) && (out_y_reg == hm1)) begin
                            in_x_reg     <= '0;
                            in_y_reg     <= '0;
                            in_cmod_reg  <= '0;
                            in_ymod_reg  <= '0;
                            out_x_reg    <= '0;
                            out_y_reg    <= '0;
                            out_ymod_reg <= '0;
                        end else if (out_x_reg == wm1) begin
                            out_x_reg    <= '0;
                            out_y_reg    <= out_y_reg + 1'b1;
                            out_ymod_reg <= sbb_pkg::mod_inc(out_ymod_reg);
                        end else begin
                            out_x_reg <= out_x_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* tb/separable_box_blur_rgb_test.sv */
// ----------------------------------------------------------------------------
// separable_box_blur_rgb_test
// Drives whole and broken frames of random RGB pixels with drain items through
// the box blur under several window settings, with random idling on both
// channels. A blur predictor computes each expected output pixel, and a
// scoreboard checks the outputs in order, field by field.
// ----------------------------------------------------------------------------
module separable_box_blur_rgb_test;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } blur_pix_t;

    class blur_scoreboard;
        logic [10:0] width_reg;
        logic [12:0] height_reg;
        logic [2:0]  radius_reg;
        logic [23:0] row_win [sbb_pkg::WIN_DEPTH];
        logic [23:0] line_st [sbb_pkg::STORE_DEPTH];
        int unsigned in_pos;
        int unsigned out_pos;
        blur_pix_t   pending [$];
        int          errors;

        function new();
            width_reg  = sbb_pkg::RESET_WIDTH;
            height_reg = sbb_pkg::RESET_HEIGHT;
            radius_reg = sbb_pkg::RESET_RADIUS;
            foreach (row_win[i]) row_win[i] = '0;
            foreach (line_st[i]) line_st[i] = '0;
            in_pos  = 0;
            out_pos = 0;
            errors  = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > sbb_pkg::MAX_WIDTH) return sbb_pkg::MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > sbb_pkg::MAX_HEIGHT) return sbb_pkg::MAX_HEIGHT;
            return height_reg;
        endfunction

        function logic [23:0] average(int unsigned sr, int unsigned sg, int unsigned sb,
                                      int unsigned n);
            logic [7:0] a, b, c;
            if (n == 0) n = 1;
            a = 8'(sr / n);
            b = 8'(sg / n);
            c = 8'(sb / n);
            return {a, b, c};
        endfunction

        function void row_average(int unsigned y, int unsigned x, int unsigned w,
                                  int unsigned r);
            int unsigned x0, x1, sr, sg, sb, n;
            logic [23:0] p;
            x0 = (x >= r) ? x - r : 0;
            x1 = (x + r > w - 1) ? w - 1 : x + r;
            sr = 0; sg = 0; sb = 0; n = 0;
            for (int unsigned c = x0; c <= x1; c++) begin
                p = row_win[c % sbb_pkg::WIN_DEPTH];
                sr += p[23:16];
                sg += p[15:8];
                sb += p[7:0];
                n++;
            end
            if (x < sbb_pkg::MAX_WIDTH)
                line_st[(y % sbb_pkg::WIN_DEPTH) * sbb_pkg::MAX_WIDTH + x] =
                    average(sr, sg, sb, n);
        endfunction

        function void emit_ready();
            int unsigned w, h, r, total, oy, ox, ylast, xlast, y0, sr, sg, sb, n;
            logic [23:0] q;
            blur_pix_t e;
            w = eff_w(); h = eff_h(); r = radius_reg;
            total = w * h;
            if (out_pos >= total) return;
            oy = out_pos / w;
            ox = out_pos % w;
            ylast = (oy + r > h - 1) ? h - 1 : oy + r;
            xlast = (ox + r > w - 1) ? w - 1 : ox + r;
            if (in_pos <= ylast * w + xlast) return;
            y0 = (oy >= r) ? oy - r : 0;
            sr = 0; sg = 0; sb = 0; n = 0;
            for (int unsigned yy = y0; yy <= ylast; yy++) begin
                q = line_st[(yy % sbb_pkg::WIN_DEPTH) * sbb_pkg::MAX_WIDTH + ox];
                sr += q[23:16];
                sg += q[15:8];
                sb += q[7:0];
                n++;
            end
            {e.red, e.green, e.blue} = average(sr, sg, sb, n);
            e.last = (out_pos + 1 == total);
            pending.push_back(e);
            out_pos++;
            if (out_pos >= total) begin
                out_pos = 0;
                in_pos  = 0;
            end
        endfunction

        function void note_input(logic cmd, logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
            int unsigned w, h, r, y, c;
            w = eff_w(); h = eff_h(); r = radius_reg;
            if (cmd == sbb_pkg::CMD_DRAIN) begin
                emit_ready();
                return;
            end
            if (in_pos >= w * h) return;
            y = in_pos / w;
            c = in_pos % w;
            row_win[c % sbb_pkg::WIN_DEPTH] = {rd, gr, bl};
            if (c >= r) row_average(y, c - r, w, r);
            if (c == w - 1) begin
                for (int unsigned x = (c >= r) ? c - r + 1 : 0; x < w; x++)
                    row_average(y, x, w, r);
            end
            in_pos++;
            emit_ready();
        endfunction

        function void configure(logic [1:0] idx, logic [12:0] val);
            case (idx)
                sbb_pkg::REG_WIDTH:  width_reg  = val[10:0];
                sbb_pkg::REG_HEIGHT: height_reg = val;
                sbb_pkg::REG_RADIUS: radius_reg = val[2:0];
                default: return;
            endcase
            in_pos  = 0;
            out_pos = 0;
        endfunction

        function bit frame_done();
            return in_pos == 0 && out_pos == 0;
        endfunction

        function bit frame_fed();
            return in_pos >= eff_w() * eff_h();
        endfunction

        function void check(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, logic last);
            blur_pix_t e;
            if (pending.size() == 0) begin
                $error("unexpected output item: red %0d green %0d blue %0d last %0d",
                       rd, gr, bl, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (rd !== e.red) begin
                $error("out_red expected %0d actual %0d", e.red, rd);
                errors++;
            end
            if (gr !== e.green) begin
                $error("out_green expected %0d actual %0d", e.green, gr);
                errors++;
            end
            if (bl !== e.blue) begin
                $error("out_blue expected %0d actual %0d", e.blue, bl);
                errors++;
            end
            if (last !== e.last) begin
                $error("frame_last expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = sbb_pkg::CMD_PIXEL;
    logic [7:0]  s_in_red = '0;
    logic [7:0]  s_in_green = '0;
    logic [7:0]  s_in_blue = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_red;
    logic [7:0]  m_out_green;
    logic [7:0]  m_out_blue;
    logic        m_frame_last;

    blur_scoreboard sb = new();
    bit          quiet;
    int unsigned items_sent;
    int unsigned stall_left;

    separable_box_blur_rgb dut (.*);

    always #5 aclk = ~aclk;

    function automatic int unsigned pick_gap();
        int unsigned p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // output side: check accepted items, then choose next ready
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check(m_out_red, m_out_green, m_out_blue, m_frame_last);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap();
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(logic cmd, logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_in_red   <= rd;
        s_in_green <= gr;
        s_in_blue  <= bl;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(cmd, rd, gr, bl);
        items_sent++;
    endtask

    task automatic send_pixel();
        send_item(sbb_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_drain();
        send_item(sbb_pkg::CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // wait for all outputs, then for a pixel still being worked on
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        sb.configure(idx, val);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned r);
        settle();
        case ($urandom_range(0, 1))
            0: begin
                write_reg(sbb_pkg::REG_WIDTH, 13'(w));
                write_reg(sbb_pkg::REG_HEIGHT, 13'(h));
                write_reg(sbb_pkg::REG_RADIUS, 13'(r));
            end
            default: begin
                write_reg(sbb_pkg::REG_RADIUS, 13'(r));
                write_reg(sbb_pkg::REG_HEIGHT, 13'(h));
                write_reg(sbb_pkg::REG_WIDTH, 13'(w));
            end
        endcase
    endtask

    // finish the frame: pixels while it is short of input, then drains
    task automatic drain_frame();
        while (!sb.frame_done()) begin
            if (sb.frame_fed()) send_drain();
            else send_pixel();
        end
    endtask

    // one frame of pixels with stray drains; broken frames stop early
    task automatic run_frame(int unsigned pixels, bit broken);
        int unsigned cut;
        cut = broken ? $urandom_range(0, pixels) : pixels;
        for (int unsigned i = 0; i < cut; i++) begin
            if ($urandom_range(0, 7) == 0) send_drain();
            send_pixel();
        end
        if (!broken) begin
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_pixel();
            drain_frame();
        end else begin
            repeat ($urandom_range(0, 4)) send_drain();
        end
    endtask

    initial begin
        int unsigned w, h, r, p;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: unused index, radius wider than frame, extremes, excess pixels
        write_reg(sbb_pkg::REG_NONE, 13'h1FFF);
        set_frame(3, 3, 7);
        send_drain();
        send_item(sbb_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        send_item(sbb_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        send_item(sbb_pkg::CMD_PIXEL, 8'h55, 8'hAA, 8'h0F);
        send_item(sbb_pkg::CMD_PIXEL, 8'hAA, 8'h55, 8'hF0);
        send_item(sbb_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd255);
        send_item(sbb_pkg::CMD_PIXEL, 8'd0, 8'd255, 8'd0);
        send_item(sbb_pkg::CMD_PIXEL, 8'd1, 8'd254, 8'd128);
        send_item(sbb_pkg::CMD_PIXEL, 8'd127, 8'd128, 8'd1);
        send_item(sbb_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        send_item(sbb_pkg::CMD_PIXEL, 8'd9, 8'd9, 8'd9);
        send_item(sbb_pkg::CMD_PIXEL, 8'd7, 8'd7, 8'd7);
        drain_frame();
        send_drain();
        set_frame(1, 1, 0);
        send_item(sbb_pkg::CMD_PIXEL, 8'd200, 8'd100, 8'd50);
        send_drain();

        // random frames, mostly small, with clamped and extreme settings early on
        while (items_sent < 1450) begin
            quiet = ($urandom_range(0, 5) == 0);
            p = (items_sent < 350) ? $urandom_range(0, 29) : $urandom_range(3, 29);
            if (p == 0) begin
                set_frame(2047, 1, 7);
                run_frame(1024, 0);
            end else if (p == 1) begin
                set_frame(0, 8191, 7);
                run_frame(200, 1);
            end else if (p == 2) begin
                set_frame(1024, 1, 0);
                run_frame(1024, $urandom_range(0, 1));
            end else begin
                w = $urandom_range(1, 9);
                h = $urandom_range(1, 6);
                r = $urandom_range(0, 7);
                set_frame(w, h, r);
                repeat ($urandom_range(1, 3))
                    run_frame(w * h, $urandom_range(0, 9) == 0);
            end
        end
        quiet = 0;

        s_valid <= 1'b0;
        for (int i = 0; i < 200000 && sb.pending.size() > 0; i++) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.pending.size() > 0) begin
            $error("%0d output items never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* filelist.f */
rtl/sbb_pkg.sv
rtl/separable_box_blur_rgb.sv
tb/separable_box_blur_rgb_test.sv
